>>> hdl/atcc_pkg.sv
package atcc_pkg;

  // Result field widths
  localparam int unsigned CharW     = 8;
  localparam int unsigned CellAddrW = 11;
  localparam int unsigned CellValW  = 16;
  localparam int unsigned AttrW     = 8;
  localparam int unsigned ParamW    = 8;

  // Character codes
  localparam logic [CharW-1:0] ChBackspace = 8'h08;
  localparam logic [CharW-1:0] ChTab       = 8'h09;
  localparam logic [CharW-1:0] ChLineFeed  = 8'h0A;
  localparam logic [CharW-1:0] ChReturn    = 8'h0D;
  localparam logic [CharW-1:0] ChEscape    = 8'h1B;
  localparam logic [CharW-1:0] ChSpace     = 8'h20;
  localparam logic [CharW-1:0] ChTilde     = 8'h7E;
  localparam logic [CharW-1:0] ChDigit0    = 8'h30;
  localparam logic [CharW-1:0] ChDigit9    = 8'h39;
  localparam logic [CharW-1:0] ChBracket   = 8'h5B;
  localparam logic [CharW-1:0] ChSemicolon = 8'h3B;
  localparam logic [CharW-1:0] ChSgrEnd    = 8'h6D;

  localparam logic [AttrW-1:0] AttrDefault = 8'h07;
  localparam int unsigned      TabStop     = 8;

  // Byte class outside escape mode
  typedef enum logic [2:0] {
    KIND_BS,
    KIND_TAB,
    KIND_LF,
    KIND_CR,
    KIND_ESC,
    KIND_PRINT,
    KIND_OTHER
  } kind_e;

  // Byte class inside escape mode
  typedef enum logic [1:0] {
    EKIND_END,
    EKIND_SEP,
    EKIND_DIGIT,
    EKIND_OTHER
  } esc_kind_e;

  // SGR parameter phase
  typedef enum logic [1:0] {
    PH_NONE   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_ENDED  = 2'd2
  } phase_e;

  // Classified word passed from front to back
  typedef struct packed {
    kind_e            kind;
    esc_kind_e        esc_kind;
    logic [3:0]       digit;
    logic [CharW-1:0] code;
  } cls_word_t;

  // SGR color number to VGA color number
  function automatic logic [2:0] sgr_to_vga(input logic [2:0] idx);
    logic [2:0] res;
    case (idx)
      3'd0:    res = 3'd0;
      3'd1:    res = 3'd4;
      3'd2:    res = 3'd2;
      3'd3:    res = 3'd6;
      3'd4:    res = 3'd1;
      3'd5:    res = 3'd5;
      3'd6:    res = 3'd3;
      3'd7:    res = 3'd7;
      default: res = 3'd0;
    endcase
    return res;
  endfunction

  // Apply one SGR code to the attribute
  function automatic logic [AttrW-1:0] apply_sgr(input logic [AttrW-1:0] attr,
                                                 input logic [ParamW-1:0] code);
    logic [AttrW-1:0] res;
    logic [ParamW-1:0] off;
    res = attr;
    off = '0;
    if (code == '0) begin
      res = AttrDefault;
    end else if (code >= 8'd30 && code <= 8'd37) begin
      off = code - 8'd30;
      res = {attr[7:4], 1'b0, sgr_to_vga(off[2:0])};
    end else if (code >= 8'd40 && code <= 8'd47) begin
      off = code - 8'd40;
      res = {1'b0, sgr_to_vga(off[2:0]), attr[3:0]};
    end
    return res;
  endfunction

endpackage

>>> hdl/ansi_text_console_controller.sv
// Channel   Handshake                  Word
// input     in_valid_i / in_stall_o    char_code_i
// output    out_valid_o / out_stall_i  cell_write_o, cell_address_o, cell_value_o,
//                                      scroll_up_o, cursor_offset_o, cursor_update_o
//
// One byte per cycle is taken while the queue is not full; each byte gives one result word.
// A byte is classified on entry, waits in a two-entry queue, and its result appears
// in the output register the cycle after the back end takes it.
// The back end's state update sets the rate.
// Reset clears the cursor, escape parser and queue and sets the attribute to 0x07.
// A stalled output holds its word; the input stalls only when the queue is full.
module ansi_text_console_controller #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [atcc_pkg::CharW-1:0]      char_code_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            cell_write_o,
  output logic [atcc_pkg::CellAddrW-1:0]  cell_address_o,
  output logic [atcc_pkg::CellValW-1:0]   cell_value_o,
  output logic                            scroll_up_o,
  output logic [atcc_pkg::CellAddrW-1:0]  cursor_offset_o,
  output logic                            cursor_update_o
);
  import atcc_pkg::*;

  logic      push;
  cls_word_t push_word;
  logic      q_full;
  logic      pop;
  logic      q_empty;
  cls_word_t pop_word;

  atcc_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_word_o (push_word)
  );

  atcc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_word_o  (pop_word)
  );

  atcc_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_word_i        (pop_word),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cell_write_o    (cell_write_o),
    .cell_address_o  (cell_address_o),
    .cell_value_o    (cell_value_o),
    .scroll_up_o     (scroll_up_o),
    .cursor_offset_o (cursor_offset_o),
    .cursor_update_o (cursor_update_o)
  );

endmodule

>>> hdl/atcc_front.sv
module atcc_front (
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [atcc_pkg::CharW-1:0]   char_code_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output atcc_pkg::cls_word_t          push_word_o
);
  import atcc_pkg::*;

  // Stall while the queue has no room
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classify the byte for both modes
  always_comb begin
    push_word_o.code  = char_code_i;
    push_word_o.digit = 4'(char_code_i - ChDigit0);

    if (char_code_i == ChBackspace) begin
      push_word_o.kind = KIND_BS;
    end else if (char_code_i == ChTab) begin
      push_word_o.kind = KIND_TAB;
    end else if (char_code_i == ChLineFeed) begin
      push_word_o.kind = KIND_LF;
    end else if (char_code_i == ChReturn) begin
      push_word_o.kind = KIND_CR;
    end else if (char_code_i == ChEscape) begin
      push_word_o.kind = KIND_ESC;
    end else if (char_code_i >= ChSpace && char_code_i <= ChTilde) begin
      push_word_o.kind = KIND_PRINT;
    end else begin
      push_word_o.kind = KIND_OTHER;
    end

    if (char_code_i == ChSgrEnd) begin
      push_word_o.esc_kind = EKIND_END;
    end else if (char_code_i == ChBracket || char_code_i == ChSemicolon) begin
      push_word_o.esc_kind = EKIND_SEP;
    end else if (char_code_i >= ChDigit0 && char_code_i <= ChDigit9) begin
      push_word_o.esc_kind = EKIND_DIGIT;
    end else begin
      push_word_o.esc_kind = EKIND_OTHER;
    end
  end

endmodule

>>> hdl/atcc_queue.sv
module atcc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  atcc_pkg::cls_word_t push_word_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output atcc_pkg::cls_word_t pop_word_o
);
  import atcc_pkg::*;

  cls_word_t  slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = count_q == 2'd2;
  assign empty_o    = count_q == 2'd0;
  assign pop_word_o = slot_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold the stored words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

>>> hdl/atcc_back.sv
module atcc_back #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_empty_i,
  input  atcc_pkg::cls_word_t             q_word_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            cell_write_o,
  output logic [atcc_pkg::CellAddrW-1:0]  cell_address_o,
  output logic [atcc_pkg::CellValW-1:0]   cell_value_o,
  output logic                            scroll_up_o,
  output logic [atcc_pkg::CellAddrW-1:0]  cursor_offset_o,
  output logic                            cursor_update_o
);
  import atcc_pkg::*;

  localparam int unsigned ColW = $clog2(COLUMNS);
  localparam int unsigned RowW = (ROWS > 2) ? $clog2(ROWS) : 1;

  // Cell index, wrapped to the address width
  function automatic logic [CellAddrW-1:0] cell_idx(input logic [RowW-1:0] r,
                                                    input logic [ColW-1:0] c);
    logic [31:0] full;
    full = 32'(r) * 32'(COLUMNS) + 32'(c);
    return full[CellAddrW-1:0];
  endfunction

  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [AttrW-1:0]  attr_q, attr_d;
  logic              esc_q, esc_d;
  phase_e            phase_q, phase_d;
  logic [ParamW-1:0] pval_q, pval_d;

  logic [ColW:0]     col_n;
  logic [RowW:0]     row_n;
  logic [11:0]       acc;

  logic                 wr;
  logic [CellAddrW-1:0] addr;
  logic [CellValW-1:0]  val;
  logic                 scr;
  logic                 upd;

  logic                 out_valid_q;
  logic                 wr_q, scr_q, upd_q;
  logic [CellAddrW-1:0] addr_q, cur_q;
  logic [CellValW-1:0]  val_q;

  // Take the next word whenever the output register frees up
  assign pop_o = !q_empty_i && (!out_valid_q || !out_stall_i);

  // Step the cursor, attribute and escape parser
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    attr_d  = attr_q;
    esc_d   = esc_q;
    phase_d = phase_q;
    pval_d  = pval_q;
    col_n   = {1'b0, col_q};
    row_n   = {1'b0, row_q};
    acc     = 12'({pval_q, 3'b000}) + 12'({pval_q, 1'b0}) + 12'(q_word_i.digit);
    wr      = 1'b0;
    addr    = '0;
    val     = '0;
    scr     = 1'b0;
    upd     = 1'b0;

    if (esc_q) begin
      case (q_word_i.esc_kind)
        EKIND_END: begin
          if (phase_q != PH_NONE) begin
            attr_d = apply_sgr(attr_q, pval_q);
          end
          esc_d   = 1'b0;
          phase_d = PH_NONE;
          pval_d  = '0;
        end
        EKIND_SEP: begin
          if (phase_q != PH_NONE) begin
            attr_d = apply_sgr(attr_q, pval_q);
          end
          phase_d = PH_DIGITS;
          pval_d  = '0;
        end
        EKIND_DIGIT: begin
          if (phase_q == PH_DIGITS) begin
            pval_d = (acc > 12'd255) ? 8'hFF : acc[ParamW-1:0];
          end
        end
        default: begin
          if (phase_q == PH_DIGITS) begin
            phase_d = PH_ENDED;
          end
        end
      endcase
    end else begin
      upd = 1'b1;
      case (q_word_i.kind)
        KIND_BS: begin
          if (col_q != '0) begin
            col_n = col_n - (ColW+1)'(1);
          end
          wr   = 1'b1;
          addr = cell_idx(row_q, col_n[ColW-1:0]);
          val  = {attr_q, ChSpace};
        end
        KIND_TAB: begin
          col_n = (col_n + (ColW+1)'(TabStop)) & ~(ColW+1)'(TabStop - 1);
        end
        KIND_LF: begin
          col_n = '0;
          row_n = row_n + (RowW+1)'(1);
        end
        KIND_CR: begin
          col_n = '0;
        end
        KIND_ESC: begin
          esc_d   = 1'b1;
          phase_d = PH_NONE;
          pval_d  = '0;
        end
        KIND_PRINT: begin
          wr    = 1'b1;
          addr  = cell_idx(row_q, col_q);
          val   = {attr_q, q_word_i.code};
          col_n = col_n + (ColW+1)'(1);
        end
        default: begin
        end
      endcase
      // Wrap past the last column, scroll past the last row
      if (col_n >= (ColW+1)'(COLUMNS)) begin
        col_n = '0;
        row_n = row_n + (RowW+1)'(1);
      end
      if (row_n >= (RowW+1)'(ROWS)) begin
        scr   = 1'b1;
        row_n = (RowW+1)'(ROWS - 1);
      end
      col_d = col_n[ColW-1:0];
      row_d = row_n[RowW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      attr_q      <= AttrDefault;
      esc_q       <= 1'b0;
      phase_q     <= PH_NONE;
      pval_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        col_q   <= col_d;
        row_q   <= row_d;
        attr_q  <= attr_d;
        esc_q   <= esc_d;
        phase_q <= phase_d;
        pval_q  <= pval_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result word; hold it while stalled
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      wr_q   <= wr;
      addr_q <= addr;
      val_q  <= val;
      scr_q  <= scr;
      cur_q  <= cell_idx(row_d, col_d);
      upd_q  <= upd;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cell_write_o    = wr_q;
  assign cell_address_o  = addr_q;
  assign cell_value_o    = val_q;
  assign scroll_up_o     = scr_q;
  assign cursor_offset_o = cur_q;
  assign cursor_update_o = upd_q;

endmodule

>>> dv/tb_ansi_text_console_controller.sv
module tb_ansi_text_console_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import atcc_pkg::*;

  localparam int unsigned Columns     = 80;
  localparam int unsigned Rows        = 25;
  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned RandomChars = 700;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned TimeoutNs   = 5_000_000;

  // SGR color index to VGA color number
  localparam logic [2:0] VgaColor [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

  typedef struct packed {
    logic                 wr;
    logic [CellAddrW-1:0] addr;
    logic [CellValW-1:0]  val;
    logic                 scroll;
    logic [CellAddrW-1:0] cur;
    logic                 upd;
  } screen_op_t;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             typed;
    screen_op_t       want;
  } char_row_t;

  // Opening sequence; rows with typed set carry a hand-written result
  localparam char_row_t OpeningChars [28] = '{
    '{8'h41,       1'b1, '{1'b1, 11'd0, 16'h0741, 1'b0, 11'd1,  1'b1}},
    '{ChBackspace, 1'b1, '{1'b1, 11'd0, 16'h0720, 1'b0, 11'd0,  1'b1}},
    '{ChBackspace, 1'b1, '{1'b1, 11'd0, 16'h0720, 1'b0, 11'd0,  1'b1}},
    '{ChSpace,     1'b1, '{1'b1, 11'd0, 16'h0720, 1'b0, 11'd1,  1'b1}},
    '{ChTilde,     1'b1, '{1'b1, 11'd1, 16'h077E, 1'b0, 11'd2,  1'b1}},
    '{8'h7F,       1'b1, '{1'b0, 11'd0, 16'h0000, 1'b0, 11'd2,  1'b1}},
    '{8'hFF,       1'b1, '{1'b0, 11'd0, 16'h0000, 1'b0, 11'd2,  1'b1}},
    '{8'h00,       1'b1, '{1'b0, 11'd0, 16'h0000, 1'b0, 11'd2,  1'b1}},
    '{ChTab,       1'b1, '{1'b0, 11'd0, 16'h0000, 1'b0, 11'd8,  1'b1}},
    '{ChReturn,    1'b1, '{1'b0, 11'd0, 16'h0000, 1'b0, 11'd0,  1'b1}},
    '{ChLineFeed,  1'b1, '{1'b0, 11'd0, 16'h0000, 1'b0, 11'd80, 1'b1}},
    '{ChEscape,    1'b1, '{1'b0, 11'd0, 16'h0000, 1'b0, 11'd80, 1'b1}},
    '{ChBracket,        1'b0, '0},
    '{ChDigit0 + 8'd3,  1'b0, '0},
    '{ChDigit0 + 8'd1,  1'b0, '0},
    '{ChSemicolon,      1'b0, '0},
    '{ChDigit0 + 8'd4,  1'b0, '0},
    '{ChDigit0 + 8'd4,  1'b0, '0},
    '{ChSgrEnd,         1'b0, '0},
    '{8'h78,            1'b0, '0},
    '{ChEscape,         1'b0, '0},
    '{ChBracket,        1'b0, '0},
    '{ChDigit9,         1'b0, '0},
    '{ChDigit9,         1'b0, '0},
    '{ChDigit9,         1'b0, '0},
    '{ChSemicolon,      1'b0, '0},
    '{ChSgrEnd,         1'b0, '0},
    '{8'h79,            1'b0, '0}
  };

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [CharW-1:0]     char_code_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 cell_write_o;
  logic [CellAddrW-1:0] cell_address_o;
  logic [CellValW-1:0]  cell_value_o;
  logic                 scroll_up_o;
  logic [CellAddrW-1:0] cursor_offset_o;
  logic                 cursor_update_o;

  // Console state as predicted
  logic [6:0]        cur_col;
  logic [4:0]        cur_row;
  logic [AttrW-1:0]  text_attr;
  logic              in_escape;
  phase_e            sgr_phase;
  logic [ParamW-1:0] sgr_value;

  screen_op_t  ops_due [$];
  int unsigned chars_sent     = 0;
  int unsigned fails          = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  int unsigned hold_left      = 0;

  ansi_text_console_controller #(
    .COLUMNS(Columns),
    .ROWS   (Rows)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cell_write_o   (cell_write_o),
    .cell_address_o (cell_address_o),
    .cell_value_o   (cell_value_o),
    .scroll_up_o    (scroll_up_o),
    .cursor_offset_o(cursor_offset_o),
    .cursor_update_o(cursor_update_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic logic [CellAddrW-1:0] cell_at(input int row, input int col);
    return CellAddrW'(row * int'(Columns) + col);
  endfunction

  // Apply one SGR code to the predicted attribute
  function automatic void take_sgr(input int code);
    if (code == 0) begin
      text_attr = AttrDefault;
    end else if (code >= 30 && code <= 37) begin
      text_attr[3:0] = {1'b0, VgaColor[code - 30]};
    end else if (code >= 40 && code <= 47) begin
      text_attr[7:4] = {1'b0, VgaColor[code - 40]};
    end
  endfunction

  // Advance the console state by one character and form its screen op
  function automatic screen_op_t next_screen_op(input logic [CharW-1:0] ch);
    screen_op_t op;
    int col;
    int row;
    int v;
    op  = '0;
    col = int'(cur_col);
    row = int'(cur_row);
    if (in_escape) begin
      if (ch == ChSgrEnd) begin
        if (sgr_phase != PH_NONE) take_sgr(int'(sgr_value));
        in_escape = 1'b0;
        sgr_phase = PH_NONE;
        sgr_value = '0;
      end else if (ch == ChBracket || ch == ChSemicolon) begin
        if (sgr_phase != PH_NONE) take_sgr(int'(sgr_value));
        sgr_phase = PH_DIGITS;
        sgr_value = '0;
      end else if (ch >= ChDigit0 && ch <= ChDigit9) begin
        if (sgr_phase == PH_DIGITS) begin
          v = int'(sgr_value) * 10 + int'(ch - ChDigit0);
          sgr_value = (v > 255) ? 8'd255 : ParamW'(v);
        end
      end else if (sgr_phase == PH_DIGITS) begin
        sgr_phase = PH_ENDED;
      end
    end else begin
      op.upd = 1'b1;
      case (ch)
        ChBackspace: begin
          if (col != 0) col--;
          op.wr   = 1'b1;
          op.addr = cell_at(row, col);
          op.val  = {text_attr, ChSpace};
        end
        ChTab:      col = (col / int'(TabStop) + 1) * int'(TabStop);
        ChLineFeed: begin
          col = 0;
          row++;
        end
        ChReturn:   col = 0;
        ChEscape: begin
          in_escape = 1'b1;
          sgr_phase = PH_NONE;
          sgr_value = '0;
        end
        default: begin
          if (ch >= ChSpace && ch <= ChTilde) begin
            op.wr   = 1'b1;
            op.addr = cell_at(row, col);
            op.val  = {text_attr, ch};
            col++;
          end
        end
      endcase
      // Wrap past the last column, scroll past the last row
      if (col >= int'(Columns)) begin
        col = 0;
        row++;
      end
      if (row >= int'(Rows)) begin
        op.scroll = 1'b1;
        row = int'(Rows) - 1;
      end
      cur_col = 7'(col);
      cur_row = 5'(row);
    end
    op.cur = cell_at(int'(cur_row), int'(cur_col));
    return op;
  endfunction

  // Offer one character word and hold it until taken
  task automatic offer_char(input logic [CharW-1:0] ch);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= ch;
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
  endtask

  task automatic send_char(input logic [CharW-1:0] ch);
    offer_char(ch);
    ops_due.push_back(next_screen_op(ch));
  endtask

  task automatic send_number(input int value);
    string digits;
    digits = $sformatf("%0d", value);
    for (int i = 0; i < digits.len(); i++) send_char(digits[i]);
  endtask

  // Mostly well-formed text and SGR sequences, some broken ones and noise
  task automatic send_random_chunk();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      n = $urandom_range(1, 16);
      repeat (n) send_char(CharW'($urandom_range(ChSpace, ChTilde)));
    end else if (pick < 55) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0:       send_char(ChBackspace);
          1:       send_char(ChTab);
          2:       send_char(ChLineFeed);
          default: send_char(ChReturn);
        endcase
      end
    end else if (pick < 80) begin
      send_char(ChEscape);
      send_char(ChBracket);
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        if (i > 0) send_char(ChSemicolon);
        case ($urandom_range(0, 4))
          0:       send_number(0);
          1:       send_number(30 + $urandom_range(0, 7));
          2:       send_number(40 + $urandom_range(0, 7));
          3:       send_number($urandom_range(0, 999));
          default: ;  // leave the parameter empty
        endcase
      end
      send_char(ChSgrEnd);
    end else if (pick < 92) begin
      send_char(ChEscape);
      n = $urandom_range(1, 6);
      repeat (n) send_char(CharW'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) != 0) send_char(ChSgrEnd);
    end else begin
      send_char(CharW'($urandom_range(0, 255)));
    end
  endtask

  // Compare one result word with the oldest pending screen op
  task automatic check_screen_op();
    screen_op_t want;
    if (ops_due.size() == 0) begin
      $error("result word with no character pending");
      fails++;
    end else begin
      want = ops_due.pop_front();
      if (cell_write_o !== want.wr) begin
        $error("cell_write: expected %0d, got %0d", want.wr, cell_write_o);
        fails++;
      end
      if (cell_address_o !== want.addr) begin
        $error("cell_address: expected %0d, got %0d", want.addr, cell_address_o);
        fails++;
      end
      if (cell_value_o !== want.val) begin
        $error("cell_value: expected %h, got %h", want.val, cell_value_o);
        fails++;
      end
      if (scroll_up_o !== want.scroll) begin
        $error("scroll_up: expected %0d, got %0d", want.scroll, scroll_up_o);
        fails++;
      end
      if (cursor_offset_o !== want.cur) begin
        $error("cursor_offset: expected %0d, got %0d", want.cur, cursor_offset_o);
        fails++;
      end
      if (cursor_update_o !== want.upd) begin
        $error("cursor_update: expected %0d, got %0d", want.upd, cursor_update_o);
        fails++;
      end
    end
  endtask

  // Receiver: check taken words, stall at random or for a long hold
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_screen_op();
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  initial begin
    #(TimeoutNs * 1ns);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    screen_op_t op;
    int unsigned phase_end;
    cur_col   = '0;
    cur_row   = '0;
    text_attr = AttrDefault;
    in_escape = 1'b0;
    sgr_phase = PH_NONE;
    sgr_value = '0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the opening sequence
    for (int i = 0; i < $size(OpeningChars); i++) begin
      offer_char(OpeningChars[i].ch);
      op = next_screen_op(OpeningChars[i].ch);
      ops_due.push_back(OpeningChars[i].typed ? OpeningChars[i].want : op);
    end

    // Random phases: receiver stalling, sender idle, then neither
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 27;
          recv_stall_pct = 65;
          hold_req       = 1'b1;  // fill the block while still offering
        end
        1: begin
          send_idle_pct  = 65;
          recv_stall_pct = 27;
          // pause until every pending word is out
          in_valid_i <= 1'b0;
          while (ops_due.size() != 0) @(posedge clk_i);
          @(posedge clk_i);
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      phase_end = chars_sent + RandomChars / 3;
      while (chars_sent < phase_end) send_random_chunk();
    end

    // Drain and settle
    in_valid_i <= 1'b0;
    while (ops_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
